@@ rtl/rv64e_pkg.sv @@
`default_nettype none
package rv64e_pkg;

  localparam int unsigned DataBytesDefault = 4096;
  localparam logic [63:0] StartPcDefault = 64'h0000_0000_8000_0000;
  localparam logic [63:0] MemBaseDefault = 64'h0000_0000_8000_0000;

  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6f;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpImmW   = 7'h1b;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpRegW   = 7'h3b;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [31:0] InstRet    = 32'h0000_8067;
  localparam logic [31:0] InstEbreak = 32'h0010_0073;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatEbreak = 2'd1;
  localparam logic [1:0] StatBad    = 2'd2;

  localparam logic [0:0] CfgStartPc = 1'b0;
  localparam logic [0:0] CfgMemBase = 1'b1;

  // Operation class chosen by the front end
  typedef enum logic [3:0] {
    K_ALU, K_JAL, K_RET, K_LOAD, K_STORE, K_BRANCH, K_MUL, K_DIV, K_EBREAK, K_BAD
  } kind_t;

  // Item handed from front end to back end
  typedef struct packed {
    logic [31:0] inst;
    kind_t       kind;
  } fe_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_EXEC, S_MEM, S_DIV, S_WB, S_OUT
  } be_state_t;

  typedef struct packed {
    logic [63:0] current_pc;
    logic [63:0] next_pc;
    logic        writes_register;
    logic [4:0]  dest_index;
    logic [63:0] dest_value;
    logic [1:0]  status;
    logic [63:0] halt_value;
  } result_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage
`default_nettype wire

@@ rtl/rv64_subset_instruction_executor.sv @@
`default_nettype none
// Executes one RV64IM-subset instruction per input item against an internal
// 32x64 register file, program counter and byte data memory, and returns one
// result item. A front queue classifies instructions; the back end reads
// registers, executes and writes back. An instruction passes through pop,
// register read, execute and writeback; stores add one memory step per byte
// (up to 8 bytes), loads one step per byte plus one to collect the last byte,
// and divw/remw by a nonzero divisor wait for the one-bit-per-cycle divider.
// A result that is not taken holds the next instruction in writeback. After
// reset the data memory is cleared byte by byte before the first item is
// executed.
module rv64_subset_instruction_executor
  import rv64e_pkg::*;
#(
  parameter int unsigned DATA_BYTES = DataBytesDefault
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // [31:0] instruction
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [63:0] current_pc, [127:64] next_pc, [128] writes_register,
  // [133:129] dest_index, [197:134] dest_value, [199:198] status,
  // [263:200] halt_value
  output logic [263:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  logic q_valid, q_pop;
  fe_item_t q_item;
  result_t res;

  assign cfg_ready = 1'b1;

  rv64e_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_inst(in_tdata), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  rv64e_back #(.DATA_BYTES(DATA_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {res.halt_value, res.status, res.dest_value, res.dest_index,
                      res.writes_register, res.next_pc, res.current_pc};

endmodule
`default_nettype wire

@@ rtl/rv64e_front.sv @@
`default_nettype none
module rv64e_front
  import rv64e_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [31:0] in_inst,
  output logic          q_valid,
  input  wire logic     q_pop,
  output fe_item_t      q_item
);

  fe_item_t slot_r [2];
  logic     wp_r, rp_r;
  logic [1:0] cnt_r;
  kind_t    kind;
  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [5:0] t6;

  // Classify the incoming word
  always_comb begin
    opc = in_inst[6:0];
    f3 = in_inst[14:12];
    f7 = in_inst[31:25];
    t6 = in_inst[31:26];
    kind = K_BAD;
    unique case (opc)
      OpAuipc: kind = K_ALU;
      OpJal: kind = K_JAL;
      OpJalr: kind = (in_inst == InstRet) ? K_RET : K_BAD;
      OpLoad: kind = (f3 == 3'd3 || f3 == 3'd2 || f3 == 3'd1 || f3 == 3'd5 || f3 == 3'd4)
                     ? K_LOAD : K_BAD;
      OpStore: kind = (f3[2] == 1'b0) ? K_STORE : K_BAD;
      OpImm: begin
        if (f3 == 3'd0 || f3 == 3'd7 || f3 == 3'd4 || f3 == 3'd3) kind = K_ALU;
        else if (f3 == 3'd1 && t6 == 6'd0) kind = K_ALU;
        else if (f3 == 3'd5 && (t6 == 6'd0 || t6 == 6'h10)) kind = K_ALU;
      end
      OpImmW: begin
        if (f3 == 3'd0 || (f3 == 3'd1 && t6 == 6'd0) || (f3 == 3'd5 && t6 == 6'h10))
          kind = K_ALU;
      end
      OpReg: begin
        if (f7 == 7'd0 && (f3 == 3'd0 || f3 == 3'd2 || f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7))
          kind = K_ALU;
        else if (f7 == 7'h20 && f3 == 3'd0) kind = K_ALU;
      end
      OpRegW: begin
        if ((f7 == 7'd0 && (f3 == 3'd0 || f3 == 3'd1)) || (f7 == 7'h20 && f3 == 3'd0))
          kind = K_ALU;
        else if (f7 == 7'd1 && f3 == 3'd0) kind = K_MUL;
        else if (f7 == 7'd1 && (f3 == 3'd4 || f3 == 3'd6)) kind = K_DIV;
      end
      OpBranch: kind = (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd4 || f3 == 3'd5)
                       ? K_BRANCH : K_BAD;
      OpSystem: kind = (in_inst == InstEbreak) ? K_EBREAK : K_BAD;
      default: kind = K_BAD;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = slot_r[rp_r];

  // Hold classified items in a two-entry queue
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slot_r[wp_r] <= '{inst: in_inst, kind: kind};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, in_valid && in_ready} - {1'b0, q_pop && q_valid};
    end
  end

endmodule
`default_nettype wire

@@ rtl/rv64e_div.sv @@
`default_nettype none
module rv64e_div
  import rv64e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quot,
  output logic [31:0]      rem
);

  logic [31:0] q_r, r_r, d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;

  assign trial = {r_r, q_r[31]} - {1'b0, d_r};
  assign quot = q_r;
  assign rem = r_r;
  assign done = busy_r && (cnt_r == 6'd32);

  // Restoring divide, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r && !done) begin
      if (!trial[32]) begin
        r_r <= trial[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        r_r <= {r_r[30:0], q_r[31]};
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/rv64e_back.sv @@
`default_nettype none
module rv64e_back
  import rv64e_pkg::*;
#(
  parameter int unsigned DATA_BYTES = DataBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  fe_item_t         q_item,
  input  wire logic        cfg_valid,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output result_t          out_res
);

  localparam int unsigned AW = $clog2(DATA_BYTES);

  be_state_t st_r, st_nxt;
  logic [63:0] regs [32];
  logic [7:0]  mem [DATA_BYTES];
  logic [63:0] pc_r, base_r;
  logic        halted_r;
  logic [AW:0] clr_r;
  logic        clearing;
  logic [31:0] inst_r;
  kind_t       kind_r;
  logic [63:0] a_r, b_r, a0_r, ra_r;
  logic [63:0] val_r, nxt_r, addr_r;
  logic [2:0]  byte_r;
  logic [31:0] prod_r;
  result_t     res_r;
  logic        ovalid_r;
  logic        wb_go;
  logic [63:0] wb_val;

  // Decode fields of the held item
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [63:0] imm_i, imm_s, imm_b, imm_j;
  logic [5:0]  sh6;
  logic [AW-1:0] slot;
  logic [63:0] sra64, srlw_in;
  logic        lts;

  assign opc = inst_r[6:0];
  assign f3 = inst_r[14:12];
  assign f7 = inst_r[31:25];
  assign rd = inst_r[11:7];
  assign sh6 = inst_r[25:20];
  assign imm_i = {{52{inst_r[31]}}, inst_r[31:20]};
  assign imm_s = {{52{inst_r[31]}}, inst_r[31:25], inst_r[11:7]};
  assign imm_b = {{51{inst_r[31]}}, inst_r[31], inst_r[7], inst_r[30:25], inst_r[11:8], 1'b0};
  assign imm_j = {{43{inst_r[31]}}, inst_r[31], inst_r[19:12], inst_r[20], inst_r[30:21], 1'b0};
  assign lts = $signed(a_r) < $signed(b_r);
  assign sra64 = $unsigned($signed(a_r) >>> sh6);
  assign srlw_in = sext32(a_r[31:0]);
  assign clearing = (clr_r != (AW + 1)'(DATA_BYTES));
  assign slot = AW'(addr_r - base_r);

  // Divider
  logic div_start, div_done;
  logic [31:0] dq, dr, ma, mb;
  logic na, nb;
  assign na = a_r[31];
  assign nb = b_r[31];
  assign ma = na ? (32'd0 - a_r[31:0]) : a_r[31:0];
  assign mb = nb ? (32'd0 - b_r[31:0]) : b_r[31:0];
  assign div_start = (st_r == S_EXEC) && (kind_r == K_DIV) && (b_r[31:0] != 32'd0);

  rv64e_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(ma), .divisor(mb), .done(div_done), .quot(dq), .rem(dr)
  );

  logic last_byte;
  logic [2:0] nbytes_m1;
  always_comb begin
    unique case (f3[1:0])
      2'd0: nbytes_m1 = 3'd0;
      2'd1: nbytes_m1 = 3'd1;
      2'd2: nbytes_m1 = 3'd3;
      default: nbytes_m1 = 3'd7;
    endcase
  end
  assign last_byte = (byte_r == nbytes_m1);

  // Retire once the output register is free or being emptied
  assign wb_go = (st_r == S_WB) && (!ovalid_r || out_ready);

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid && !clearing) st_nxt = S_READ;
      S_READ: st_nxt = S_EXEC;
      S_EXEC: begin
        if (halted_r) st_nxt = S_WB;
        else if (kind_r == K_LOAD || kind_r == K_STORE) st_nxt = S_MEM;
        else if (div_start) st_nxt = S_DIV;
        else st_nxt = S_WB;
      end
      S_MEM: if (last_byte) st_nxt = (kind_r == K_LOAD) ? S_OUT : S_WB;
      S_OUT: st_nxt = S_WB;
      S_DIV: if (div_done) st_nxt = S_WB;
      S_WB: if (!ovalid_r || out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign q_pop = (st_r == S_IDLE) && q_valid && !clearing;
  assign out_valid = ovalid_r;
  assign out_res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  // Final writeback value with load extension and word product
  always_comb begin
    wb_val = val_r;
    if (kind_r == K_MUL) wb_val = sext32(prod_r);
    else if (kind_r == K_LOAD) begin
      unique case (f3)
        3'd2: wb_val = sext32(val_r[31:0]);
        3'd1: wb_val = {{48{val_r[15]}}, val_r[15:0]};
        3'd5: wb_val = {48'd0, val_r[15:0]};
        3'd4: wb_val = {56'd0, val_r[7:0]};
        default: wb_val = val_r;
      endcase
    end
  end

  // Register file write and reads
  logic wr_en;
  assign wr_en = wb_go && !halted_r && (kind_r != K_BAD)
                 && (kind_r != K_EBREAK) && (rd != 5'd0)
                 && (kind_r == K_ALU || kind_r == K_JAL || kind_r == K_LOAD
                     || kind_r == K_MUL || kind_r == K_DIV);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) regs[i] <= '0;
    end else if (wr_en) begin
      regs[rd] <= wb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      inst_r <= q_item.inst;
      kind_r <= q_item.kind;
    end
    if (st_r == S_READ) begin
      a_r <= regs[inst_r[19:15]];
      b_r <= regs[inst_r[24:20]];
      a0_r <= regs[10];
      ra_r <= regs[1];
    end
  end

  // Memory: clearing pass, byte stores, byte loads
  logic [7:0] rd_byte;
  always_ff @(posedge clk) begin
    if (clearing) mem[clr_r[AW-1:0]] <= 8'd0;
    else if (st_r == S_MEM && kind_r == K_STORE) mem[slot] <= b_r[8*byte_r +: 8];
    rd_byte <= mem[slot];
  end

  logic ld_pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (clearing) clr_r <= clr_r + (AW + 1)'(1);
  end

  // Execute and sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= StartPcDefault;
      base_r <= MemBaseDefault;
      halted_r <= 1'b0;
      ovalid_r <= 1'b0;
      ld_pend_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CfgStartPc) pc_r <= cfg_data;
        else base_r <= cfg_data;
      end
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      ld_pend_r <= 1'b0;
      unique case (st_r)
        S_EXEC: begin
          val_r <= '0;
          nxt_r <= pc_r + 64'd4;
          byte_r <= 3'd0;
          addr_r <= a_r + ((kind_r == K_STORE) ? imm_s : imm_i);
          prod_r <= a_r[31:0] * b_r[31:0];
          unique case (kind_r)
            K_JAL: begin
              val_r <= pc_r + 64'd4;
              nxt_r <= pc_r + imm_j;
            end
            K_RET: nxt_r <= {ra_r[63:1], 1'b0};
            K_BRANCH: begin
              if ((f3 == 3'd0 && a_r == b_r) || (f3 == 3'd1 && a_r != b_r)
                  || (f3 == 3'd4 && lts) || (f3 == 3'd5 && !lts))
                nxt_r <= pc_r + imm_b;
            end
            K_DIV: begin
              if (b_r[31:0] == 32'd0)
                val_r <= (f3 == 3'd6) ? sext32(a_r[31:0]) : '1;
            end
            K_ALU: begin
              if (opc == OpAuipc) val_r <= pc_r + sext32({inst_r[31:12], 12'd0});
              else if (opc == OpImm) begin
                unique case (f3)
                  3'd0: val_r <= a_r + imm_i;
                  3'd7: val_r <= a_r & imm_i;
                  3'd4: val_r <= a_r ^ imm_i;
                  3'd3: val_r <= {63'd0, a_r < imm_i};
                  3'd1: val_r <= a_r << sh6;
                  3'd5: val_r <= inst_r[30] ? sra64 : (a_r >> sh6);
                  default: val_r <= '0;
                endcase
              end else if (opc == OpImmW) begin
                unique case (f3)
                  3'd0: val_r <= sext32(a_r[31:0] + imm_i[31:0]);
                  3'd1: val_r <= sext32(32'(a_r << sh6));
                  default: val_r <= $unsigned($signed(srlw_in) >>> sh6[4:0]);
                endcase
              end else if (opc == OpReg) begin
                unique case (f3)
                  3'd0: val_r <= f7[5] ? (a_r - b_r) : (a_r + b_r);
                  3'd2: val_r <= {63'd0, lts};
                  3'd3: val_r <= {63'd0, a_r < b_r};
                  3'd6: val_r <= a_r | b_r;
                  default: val_r <= a_r & b_r;
                endcase
              end else begin
                if (f3 == 3'd1) val_r <= sext32(a_r[31:0] << b_r[4:0]);
                else val_r <= sext32(f7[5] ? (a_r[31:0] - b_r[31:0])
                                           : (a_r[31:0] + b_r[31:0]));
              end
            end
            default: val_r <= '0;
          endcase
        end
        S_MEM: begin
          // Loads: issue read of one byte, collect it next cycle
          if (kind_r == K_LOAD) ld_pend_r <= 1'b1;
          if (!last_byte) begin
            byte_r <= byte_r + 3'd1;
            addr_r <= addr_r + 64'd1;
          end
        end
        default: ;
      endcase
      if (ld_pend_r) begin
        val_r[8*(byte_r - ((st_r == S_MEM) ? 3'd1 : 3'd0)) +: 8] <= rd_byte;
      end
      if (st_r == S_DIV && div_done) begin
        if (f3 == 3'd6) val_r <= sext32(na ? (32'd0 - dr) : dr);
        else val_r <= sext32((na ^ nb) ? (32'd0 - dq) : dq);
      end
      if (wb_go) begin
        ovalid_r <= 1'b1;
        res_r.current_pc <= pc_r;
        res_r.halt_value <= '0;
        res_r.writes_register <= wr_en;
        res_r.dest_index <= wr_en ? rd : 5'd0;
        res_r.dest_value <= wr_en ? wb_val : '0;
        if (halted_r) begin
          res_r.next_pc <= pc_r;
          res_r.status <= StatBad;
        end else if (kind_r == K_BAD) begin
          res_r.next_pc <= pc_r + 64'd4;
          res_r.status <= StatBad;
          halted_r <= 1'b1;
          pc_r <= pc_r + 64'd4;
        end else if (kind_r == K_EBREAK) begin
          res_r.next_pc <= pc_r + 64'd4;
          res_r.status <= StatEbreak;
          res_r.halt_value <= a0_r;
          halted_r <= 1'b1;
          pc_r <= pc_r + 64'd4;
        end else begin
          res_r.next_pc <= nxt_r;
          res_r.status <= StatOk;
          pc_r <= nxt_r;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/rv64e_checker.sv @@
`default_nettype none
module rv64e_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [263:0] out_tdata
);

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[199:198] != 2'd3) else $error("bad status");
  a_x0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[128] |-> out_tdata[133:129] != 5'd0) else $error("x0 write");
  a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[128] |-> out_tdata[197:134] == 64'd0) else $error("stray value");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("drop");

endmodule

bind rv64_subset_instruction_executor rv64e_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
module tb;
  import rv64e_pkg::*;

  // Function codes that the test uses
  localparam logic [2:0] F3Add = 3'd0, F3Sll = 3'd1, F3Slt = 3'd2, F3Sltu = 3'd3;
  localparam logic [2:0] F3Xor = 3'd4, F3Srl = 3'd5, F3Or = 3'd6, F3And = 3'd7;
  localparam logic [2:0] F3Div = 3'd4, F3Rem = 3'd6;
  localparam logic [2:0] F3Lb = 3'd0, F3Lh = 3'd1, F3Lw = 3'd2, F3Ld = 3'd3;
  localparam logic [2:0] F3Lbu = 3'd4, F3Lhu = 3'd5;
  localparam logic [2:0] F3Beq = 3'd0, F3Bne = 3'd1, F3Blt = 3'd4, F3Bge = 3'd5;
  localparam logic [6:0] F7Base = 7'h00, F7Alt = 7'h20, F7Mul = 7'h01;
  localparam logic [5:0] Top6Sra = 6'h10;
  localparam int DrainCycles = 80;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [31:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [263:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [0:0] cfg_index;
  logic [63:0] cfg_data;

  rv64_subset_instruction_executor u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Shadow copy of the core state
  logic [63:0] gpr [32];
  logic [7:0]  dmem [DataBytesDefault];
  logic [63:0] core_pc, mem_base;
  logic        core_halted;

  logic [31:0] inst_q [$];
  result_t     result_q [$];
  int errors, n_exec, n_results, n_halted_items;
  int out_hold;
  bit quiet, in_took;

  function automatic logic [63:0] sx(logic [63:0] v, int bits);
    logic [63:0] m;
    m = 64'd1 << (bits - 1);
    v &= (m << 1) - 64'd1;
    return (v ^ m) - m;
  endfunction

  function automatic logic [63:0] mem_rd(logic [63:0] addr, int n);
    logic [63:0] v, off;
    v = '0;
    for (int i = n - 1; i >= 0; i--) begin
      off = addr + i - mem_base;
      v = (v << 8) | dmem[off[11:0]];
    end
    return v;
  endfunction

  function automatic void mem_wr(logic [63:0] addr, int n, logic [63:0] v);
    logic [63:0] off;
    for (int i = 0; i < n; i++) begin
      off = addr + i - mem_base;
      dmem[off[11:0]] = v[7:0];
      v = v >> 8;
    end
  endfunction

  function automatic logic [63:0] word_div(logic [63:0] x, logic [63:0] y, bit want_rem);
    logic [31:0] a, b;
    a = x[31:0];
    b = y[31:0];
    if (b == 32'd0) return want_rem ? sext32(a) : '1;
    if (a == 32'h8000_0000 && b == 32'hffff_ffff) return want_rem ? 64'd0 : sext32(a);
    if (want_rem) return sext32($signed(a) % $signed(b));
    return sext32($signed(a) / $signed(b));
  endfunction

  // Execute one instruction on the shadow state
  function automatic result_t exec_inst(logic [31:0] ins);
    result_t r;
    logic [6:0] op;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [5:0] top6, sh6;
    logic [63:0] a, b, imm_i, imm_s, imm_b, imm_j, val, nxt, ad, t;
    bit wr, bad, take;
    r = '0;
    r.current_pc = core_pc;
    if (core_halted) begin
      r.next_pc = core_pc;
      r.status = StatBad;
      return r;
    end
    op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12]; f7 = ins[31:25];
    top6 = ins[31:26]; sh6 = ins[25:20];
    a = gpr[ins[19:15]]; b = gpr[ins[24:20]];
    imm_i = sx({52'd0, ins[31:20]}, 12);
    imm_s = sx({52'd0, ins[31:25], ins[11:7]}, 12);
    imm_b = sx({51'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
    imm_j = sx({43'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
    nxt = core_pc + 64'd4;
    wr = 0; bad = 0; val = '0;
    case (op)
      OpAuipc: begin wr = 1; val = core_pc + sext32({ins[31:12], 12'd0}); end
      OpJal: begin wr = 1; val = core_pc + 64'd4; nxt = core_pc + imm_j; end
      OpJalr: begin
        if (ins == InstRet) nxt = gpr[1] & ~64'd1;
        else bad = 1;
      end
      OpLoad: begin
        ad = a + imm_i; wr = 1;
        case (f3)
          F3Ld: val = mem_rd(ad, 8);
          F3Lw: val = sx(mem_rd(ad, 4), 32);
          F3Lh: val = sx(mem_rd(ad, 2), 16);
          F3Lhu: val = mem_rd(ad, 2);
          F3Lbu: val = mem_rd(ad, 1);
          default: bad = 1;
        endcase
      end
      OpStore: begin
        if (f3 <= F3Ld) mem_wr(a + imm_s, 1 << f3, b);
        else bad = 1;
      end
      OpImm: begin
        wr = 1;
        case (f3)
          F3Add: val = a + imm_i;
          F3And: val = a & imm_i;
          F3Xor: val = a ^ imm_i;
          F3Sltu: val = (a < imm_i) ? 64'd1 : 64'd0;
          F3Sll: if (top6 == 6'd0) val = a << sh6; else bad = 1;
          F3Srl: begin
            if (top6 == 6'd0) val = a >> sh6;
            else if (top6 == Top6Sra) val = $signed(a) >>> sh6;
            else bad = 1;
          end
          default: bad = 1;
        endcase
      end
      OpImmW: begin
        wr = 1;
        if (f3 == F3Add) begin
          t = a + imm_i; val = sext32(t[31:0]);
        end else if (f3 == F3Sll && top6 == 6'd0) begin
          t = a << sh6; val = sext32(t[31:0]);
        end else if (f3 == F3Srl && top6 == Top6Sra) begin
          val = $signed(sext32(a[31:0])) >>> sh6[4:0];
        end else bad = 1;
      end
      OpReg: begin
        wr = 1;
        if (f7 == F7Base && f3 == F3Add) val = a + b;
        else if (f7 == F7Base && f3 == F3Slt) val = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
        else if (f7 == F7Base && f3 == F3Sltu) val = (a < b) ? 64'd1 : 64'd0;
        else if (f7 == F7Base && f3 == F3Or) val = a | b;
        else if (f7 == F7Base && f3 == F3And) val = a & b;
        else if (f7 == F7Alt && f3 == F3Add) val = a - b;
        else bad = 1;
      end
      OpRegW: begin
        wr = 1;
        if (f7 == F7Base && f3 == F3Add) begin t = a + b; val = sext32(t[31:0]); end
        else if (f7 == F7Base && f3 == F3Sll) begin
          t = a << b[4:0]; val = sext32(t[31:0]);
        end
        else if (f7 == F7Alt && f3 == F3Add) begin t = a - b; val = sext32(t[31:0]); end
        else if (f7 == F7Mul && f3 == F3Add) begin t = a * b; val = sext32(t[31:0]); end
        else if (f7 == F7Mul && f3 == F3Div) val = word_div(a, b, 0);
        else if (f7 == F7Mul && f3 == F3Rem) val = word_div(a, b, 1);
        else bad = 1;
      end
      OpBranch: begin
        take = 0;
        case (f3)
          F3Beq: take = (a == b);
          F3Bne: take = (a != b);
          F3Blt: take = $signed(a) < $signed(b);
          F3Bge: take = !($signed(a) < $signed(b));
          default: bad = 1;
        endcase
        if (take) nxt = core_pc + imm_b;
      end
      OpSystem: begin
        if (ins == InstEbreak) begin
          r.status = StatEbreak; r.halt_value = gpr[10]; core_halted = 1;
        end else bad = 1;
      end
      default: bad = 1;
    endcase
    if (bad) begin
      wr = 0; r.status = StatBad; core_halted = 1; nxt = core_pc + 64'd4;
    end
    if (rd == 5'd0) wr = 0;
    if (wr) begin
      gpr[rd] = val;
      r.writes_register = 1'b1; r.dest_index = rd; r.dest_value = val;
    end
    core_pc = nxt;
    r.next_pc = nxt;
    return r;
  endfunction

  // Encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction
  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction
  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OpStore};
  endfunction
  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OpBranch};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 7));
  endfunction

  // Random well-formed instruction of the supported set
  function automatic logic [31:0] rand_inst();
    logic [31:0] rnd;
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [2:0] lds [5];
    logic [2:0] brs [4];
    lds = '{F3Ld, F3Lw, F3Lh, F3Lhu, F3Lbu};
    brs = '{F3Beq, F3Bne, F3Blt, F3Bge};
    rnd = $urandom();
    rd = pick_reg(); rs1 = pick_reg(); rs2 = pick_reg();
    case ($urandom_range(15))
      0: return {rnd[31:12], rd, OpAuipc};
      1: return {rnd[31:12], rd, OpJal};
      2: return InstRet;
      3, 4: return enc_i(rnd[31:20], rs1, lds[$urandom_range(4)], rd, OpLoad);
      5, 6: return enc_s(rnd[31:20], rs2, rs1, 3'($urandom_range(3)));
      7: return enc_b(rnd[12:0], rs2, rs1, brs[$urandom_range(3)]);
      8, 9: begin
        case ($urandom_range(5))
          0: f3 = F3Add; 1: f3 = F3And; 2: f3 = F3Xor; 3: f3 = F3Sltu;
          4: return {6'd0, rnd[25:20], rs1, F3Sll, rd, OpImm};
          default: return {rnd[0] ? Top6Sra : 6'd0, rnd[25:20], rs1, F3Srl, rd, OpImm};
        endcase
        return enc_i(rnd[31:20], rs1, f3, rd, OpImm);
      end
      10: begin
        case ($urandom_range(2))
          0: return enc_i(rnd[31:20], rs1, F3Add, rd, OpImmW);
          1: return {6'd0, rnd[25:20], rs1, F3Sll, rd, OpImmW};
          default: return {Top6Sra, rnd[25:20], rs1, F3Srl, rd, OpImmW};
        endcase
      end
      11, 12: begin
        case ($urandom_range(5))
          0: return enc_r(F7Base, rs2, rs1, F3Add, rd, OpReg);
          1: return enc_r(F7Base, rs2, rs1, F3Slt, rd, OpReg);
          2: return enc_r(F7Base, rs2, rs1, F3Sltu, rd, OpReg);
          3: return enc_r(F7Base, rs2, rs1, F3Or, rd, OpReg);
          4: return enc_r(F7Base, rs2, rs1, F3And, rd, OpReg);
          default: return enc_r(F7Alt, rs2, rs1, F3Add, rd, OpReg);
        endcase
      end
      default: begin
        case ($urandom_range(5))
          0: return enc_r(F7Base, rs2, rs1, F3Add, rd, OpRegW);
          1: return enc_r(F7Base, rs2, rs1, F3Sll, rd, OpRegW);
          2: return enc_r(F7Alt, rs2, rs1, F3Add, rd, OpRegW);
          3: return enc_r(F7Mul, rs2, rs1, F3Add, rd, OpRegW);
          4: return enc_r(F7Mul, rs2, rs1, F3Div, rd, OpRegW);
          default: return enc_r(F7Mul, rs2, rs1, F3Rem, rd, OpRegW);
        endcase
      end
    endcase
  endfunction

  // Input side: record accepted items and predict their results
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      in_took = 1;
      result_q.push_back(exec_inst(in_tdata));
      n_exec++;
    end
  end

  // Drive instructions; hold an item until it is taken
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_took)) begin
      in_took = 0;
      if (inst_q.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
        in_tdata <= inst_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result ready with random stalls and one long hold-off
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || $urandom_range(99) >= 8;
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.current_pc = out_tdata[63:0];
      got.next_pc = out_tdata[127:64];
      got.writes_register = out_tdata[128];
      got.dest_index = out_tdata[133:129];
      got.dest_value = out_tdata[197:134];
      got.status = out_tdata[199:198];
      got.halt_value = out_tdata[263:200];
      n_results++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (want.status == StatBad && want.current_pc == want.next_pc) n_halted_items++;
        if (got.current_pc !== want.current_pc)
          $display("%0t: current_pc exp %h got %h", $time, want.current_pc, got.current_pc);
        if (got.next_pc !== want.next_pc)
          $display("%0t: next_pc exp %h got %h", $time, want.next_pc, got.next_pc);
        if (got.writes_register !== want.writes_register)
          $display("%0t: writes_register exp %b got %b", $time, want.writes_register,
                   got.writes_register);
        if (got.dest_index !== want.dest_index)
          $display("%0t: dest_index exp %0d got %0d", $time, want.dest_index, got.dest_index);
        if (got.dest_value !== want.dest_value)
          $display("%0t: dest_value exp %h got %h", $time, want.dest_value, got.dest_value);
        if (got.status !== want.status)
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        if (got.halt_value !== want.halt_value)
          $display("%0t: halt_value exp %h got %h", $time, want.halt_value, got.halt_value);
        if (got !== want) errors++;
      end
    end
  end

  task automatic drain();
    while (inst_q.size() != 0 || in_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgStartPc) core_pc = val;
    else mem_base = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [63:0] pc_set [4];
    logic [63:0] base_set [4];
    pc_set = '{64'd0, 64'hffff_ffff_ffff_fffc, 64'h0000_0000_8000_0000, 64'd0};
    base_set = '{64'd0, 64'hffff_ffff_ffff_ffff, 64'h0000_0000_8000_0000, 64'd0};
    pc_set[3] = {$urandom(), $urandom()};
    base_set[3] = {$urandom(), $urandom()};
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    core_pc = StartPcDefault;
    mem_base = MemBaseDefault;
    core_halted = 0;
    errors = 0; n_exec = 0; n_results = 0; n_halted_items = 0;
    out_hold = 0; quiet = 0; in_took = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme values, shifts, divide corner cases, wrapping memory
    inst_q.push_back(enc_i(12'hfff, 5'd0, F3Add, 5'd1, OpImm));
    inst_q.push_back(enc_i(12'h7ff, 5'd0, F3Add, 5'd2, OpImm));
    inst_q.push_back(enc_i(12'h800, 5'd0, F3Add, 5'd3, OpImm));
    inst_q.push_back({6'd0, 6'd63, 5'd1, F3Sll, 5'd4, OpImm});
    inst_q.push_back({Top6Sra, 6'd63, 5'd4, F3Srl, 5'd5, OpImm});
    inst_q.push_back({6'd0, 6'd63, 5'd4, F3Srl, 5'd6, OpImm});
    inst_q.push_back({Top6Sra, 6'd63, 5'd1, F3Srl, 5'd7, OpImmW});
    inst_q.push_back({6'd0, 6'd33, 5'd2, F3Sll, 5'd8, OpImmW});
    inst_q.push_back(enc_r(F7Base, 5'd1, 5'd1, F3Add, 5'd0, OpReg));
    inst_q.push_back(enc_i(12'd1, 5'd0, F3Add, 5'd9, OpImm));
    inst_q.push_back({6'd0, 6'd31, 5'd9, F3Sll, 5'd9, OpImm});
    inst_q.push_back(enc_r(F7Mul, 5'd1, 5'd9, F3Div, 5'd11, OpRegW));
    inst_q.push_back(enc_r(F7Mul, 5'd1, 5'd9, F3Rem, 5'd12, OpRegW));
    inst_q.push_back(enc_r(F7Mul, 5'd0, 5'd9, F3Div, 5'd13, OpRegW));
    inst_q.push_back(enc_r(F7Mul, 5'd0, 5'd9, F3Rem, 5'd14, OpRegW));
    inst_q.push_back(enc_r(F7Mul, 5'd9, 5'd1, F3Add, 5'd15, OpRegW));
    inst_q.push_back(enc_s(12'hff8, 5'd4, 5'd0, F3Ld));
    inst_q.push_back(enc_i(12'hffd, 5'd0, F3Ld, 5'd16, OpLoad));
    inst_q.push_back(enc_i(12'hffb, 5'd0, F3Lw, 5'd17, OpLoad));
    inst_q.push_back(enc_i(12'hfff, 5'd0, F3Lh, 5'd18, OpLoad));
    inst_q.push_back(enc_i(12'hfff, 5'd0, F3Lhu, 5'd19, OpLoad));
    inst_q.push_back(enc_i(12'hfff, 5'd0, F3Lbu, 5'd20, OpLoad));
    inst_q.push_back(enc_b(13'h1ffc, 5'd0, 5'd4, F3Blt));
    inst_q.push_back(enc_b(13'd8, 5'd4, 5'd0, F3Bge));
    inst_q.push_back({1'b0, 10'd4, 1'b0, 8'd0, 5'd1, OpJal});
    inst_q.push_back(InstRet);
    inst_q.push_back({20'hfffff, 5'd21, OpAuipc});
    drain();

    // Random phases under different register settings
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_reg(CfgStartPc, pc_set[ph - 1]);
        write_reg(CfgMemBase, base_set[ph - 1]);
      end
      quiet = (ph == 2);
      for (int i = 0; i < 300; i++) inst_q.push_back(rand_inst());
      if (ph == 1) begin
        repeat (20) @(posedge clk);
        out_hold = 400;
      end
      drain();
    end

    // Halt by ebreak; everything after it is ignored
    quiet = 0;
    inst_q.push_back(InstEbreak);
    for (int i = 0; i < 6; i++) inst_q.push_back($urandom());
    drain();

    $display("Ran %0d instructions over five register settings, %0d results checked.",
             n_exec, n_results);
    $display("Covered divide corner cases, wrapping memory, ebreak halt, %0d halted items.",
             n_halted_items);
    if (errors == 0 && result_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
